### rtl/b64u_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64u_pkg: shared types and constants for the base64url decoder
// Transaction payloads, the symbol class code and the alphabet constants.
// ----------------------------------------------------------------------------
package b64u_pkg;

    // Input transaction: one text character
    typedef struct packed {
        logic [7:0] text_char;
        logic       is_final;
    } char_item_t;

    // Output transaction: one result per character
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       token_done;
        logic       decode_error;
    } result_item_t;

    // Class of a character as seen by the front end
    typedef enum logic [1:0] {
        SYM_DATA,
        SYM_PAD,
        SYM_BAD
    } sym_class_t;

    // Classified character held in the queue
    typedef struct packed {
        sym_class_t cls;
        logic [5:0] value;
        logic       is_final;
    } sym_item_t;

    // Alphabet characters
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DASH    = 8'h2D;
    localparam logic [7:0] CHAR_USCORE  = 8'h5F;
    localparam logic [7:0] CHAR_PAD     = 8'h3D;

    // Symbol value offsets
    localparam logic [5:0] LOWER_BASE = 6'd26;
    localparam logic [5:0] DIGIT_BASE = 6'd52;
    localparam logic [5:0] DASH_VALUE = 6'd62;
    localparam logic [5:0] USCORE_VALUE = 6'd63;

    // Accumulator geometry
    localparam int unsigned ACC_W   = 12;
    localparam int unsigned SYM_W   = 6;
    localparam int unsigned BYTE_W  = 8;

endpackage

### rtl/b64u_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64u_front: character front end
// Accepts characters and maps each to a symbol class and 6-bit value.
// ----------------------------------------------------------------------------
module b64u_front (
    input  logic                  char_valid,
    output logic                  char_ready,
    input  b64u_pkg::char_item_t  char_data,
    input  logic                  q_ready,
    output logic                  q_push,
    output b64u_pkg::sym_item_t   q_data
);

    logic [7:0] ch;

    assign ch         = char_data.text_char;
    assign char_ready = q_ready;
    assign q_push     = char_valid && q_ready;

    // Alphabet decode
    always_comb
    begin
        q_data.cls      = b64u_pkg::SYM_BAD;
        q_data.value    = '0;
        q_data.is_final = char_data.is_final;
        unique case (ch) inside
            [8'h41:8'h5A]:
            begin
                q_data.cls   = b64u_pkg::SYM_DATA;
                q_data.value = 6'(ch - b64u_pkg::CHAR_UPPER_A);
            end
            [8'h61:8'h7A]:
            begin
                q_data.cls   = b64u_pkg::SYM_DATA;
                q_data.value = 6'(ch - b64u_pkg::CHAR_LOWER_A) + b64u_pkg::LOWER_BASE;
            end
            [8'h30:8'h39]:
            begin
                q_data.cls   = b64u_pkg::SYM_DATA;
                q_data.value = 6'(ch - b64u_pkg::CHAR_DIGIT_0) + b64u_pkg::DIGIT_BASE;
            end
            b64u_pkg::CHAR_DASH:
            begin
                q_data.cls   = b64u_pkg::SYM_DATA;
                q_data.value = b64u_pkg::DASH_VALUE;
            end
            b64u_pkg::CHAR_USCORE:
            begin
                q_data.cls   = b64u_pkg::SYM_DATA;
                q_data.value = b64u_pkg::USCORE_VALUE;
            end
            b64u_pkg::CHAR_PAD:
            begin
                q_data.cls = b64u_pkg::SYM_PAD;
            end
            default:
            begin
                q_data.cls = b64u_pkg::SYM_BAD;
            end
        endcase
    end

endmodule

### rtl/b64u_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64u_queue: small symbol queue
// Register-based FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module b64u_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  b64u_pkg::sym_item_t  push_data,
    output logic                 not_full,
    input  logic                 pop,
    output logic                 not_empty,
    output b64u_pkg::sym_item_t  pop_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    b64u_pkg::sym_item_t  entry_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;

    assign not_full  = (count_reg != FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/b64u_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64u_back: decode back end
// Shifts symbols into the accumulator, emits bytes, tracks pad and error.
// ----------------------------------------------------------------------------
module b64u_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    input  b64u_pkg::sym_item_t    q_data,
    output logic                   q_pop,
    output logic                   res_valid,
    input  logic                   res_ready,
    output b64u_pkg::result_item_t res_data
);

    localparam int unsigned ACC_W  = b64u_pkg::ACC_W;
    localparam int unsigned SYM_W  = b64u_pkg::SYM_W;
    localparam int unsigned BYTE_W = b64u_pkg::BYTE_W;

    logic [ACC_W-1:0]        acc_reg, acc_next;
    logic [2:0]              held_reg, held_next;
    logic                    pad_reg, pad_next;
    logic                    err_reg, err_next;
    logic                    res_valid_reg, res_valid_next;
    b64u_pkg::result_item_t  res_data_reg, res_data_next;

    logic [ACC_W-1:0]        acc_shift;
    logic [3:0]              bit_sum;
    logic [2:0]              bit_rem;
    logic [ACC_W-1:0]        acc_aligned;

    assign q_pop     = q_valid && (!res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    // Accumulator arithmetic
    assign acc_shift   = {acc_reg[ACC_W-SYM_W-1:0], q_data.value};
    assign bit_sum     = {1'b0, held_reg} + 4'd6;
    assign bit_rem     = 3'(bit_sum - 4'd8);
    assign acc_aligned = acc_shift >> bit_rem;

    // Next state and result
    always_comb
    begin
        acc_next       = acc_reg;
        held_next      = held_reg;
        pad_next       = pad_reg;
        err_next       = err_reg;
        res_valid_next = res_valid_reg && !res_ready;
        res_data_next  = res_data_reg;
        if (q_pop)
        begin
            res_data_next.data_byte  = '0;
            res_data_next.byte_valid = 1'b0;
            if (q_data.cls == b64u_pkg::SYM_PAD)
            begin
                pad_next = 1'b1;
            end
            else if (pad_reg || q_data.cls == b64u_pkg::SYM_BAD)
            begin
                err_next = 1'b1;
            end
            else if (!err_reg)
            begin
                acc_next = acc_shift;
                if (bit_sum >= 4'd8)
                begin
                    held_next                = bit_rem;
                    res_data_next.data_byte  = acc_aligned[BYTE_W-1:0];
                    res_data_next.byte_valid = 1'b1;
                end
                else
                begin
                    held_next = bit_sum[2:0];
                end
            end
            res_data_next.token_done   = q_data.is_final;
            res_data_next.decode_error = err_next;
            res_valid_next             = 1'b1;
            // End of token clears all running state
            if (q_data.is_final)
            begin
                acc_next  = '0;
                held_next = '0;
                pad_next  = 1'b0;
                err_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            held_reg      <= '0;
            pad_reg       <= 1'b0;
            err_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            held_reg      <= held_next;
            pad_reg       <= pad_next;
            err_reg       <= err_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Result payload register
    always_ff @(posedge clk)
    begin
        res_data_reg <= res_data_next;
    end

endmodule

### rtl/base64url_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64url_decoder_unit: streaming base64url decoder
// One character in, one result out, for every transaction.
// ----------------------------------------------------------------------------
// Usage:
//   char_* channel: one text character per transaction, is_final on the last
//   character of a token. res_* channel: exactly one result per character,
//   carrying a byte when one completes, token_done and the sticky error flag.
//   Both channels are valid/ready.
//   An accepted character is written into the symbol queue, then decoded
//   into the result register; a receiver stall can hold it in the queue.
//   Throughput: one character per cycle while results are taken; the back
//   end's accumulator update sets that figure.
//   The symbol queue lets the front end keep accepting while the receiver
//   stalls; when the queue fills, char_ready drops until results are taken.
//   Reset clears the accumulator, bit count, pad and error flags, the queue
//   and the result valid flag. The final character of a token clears the
//   decode state again, ready for the next token.
// ----------------------------------------------------------------------------
module base64url_decoder_unit #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   char_valid,
    output logic                   char_ready,
    input  b64u_pkg::char_item_t   char_data,
    output logic                   res_valid,
    input  logic                   res_ready,
    output b64u_pkg::result_item_t res_data
);

    logic                 q_push;
    logic                 q_pop;
    logic                 q_not_full;
    logic                 q_not_empty;
    b64u_pkg::sym_item_t  q_push_data;
    b64u_pkg::sym_item_t  q_pop_data;

    // Classification
    b64u_front u_front (
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_data  (char_data),
        .q_ready    (q_not_full),
        .q_push     (q_push),
        .q_data     (q_push_data)
    );

    // Decoupling queue
    b64u_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_pop_data)
    );

    // Decode and result register
    b64u_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_not_empty),
        .q_data    (q_pop_data),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

endmodule

### rtl/b64u_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64u_checker: port-level checks for the base64url decoder
// Watches the result channel and the sticky error behaviour over a token.
// ----------------------------------------------------------------------------
module b64u_checker (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   char_valid,
    input  logic                   char_ready,
    input  b64u_pkg::char_item_t   char_data,
    input  logic                   res_valid,
    input  logic                   res_ready,
    input  b64u_pkg::result_item_t res_data
);

    logic err_open_reg;
    logic in_final;

    assign in_final = char_valid && char_ready && char_data.is_final;

    // Error seen earlier in the token, not yet closed by token_done
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_open_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            err_open_reg <= res_data.decode_error && !res_data.token_done;
        end
    end

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("result changed while stalled");

    // No byte is delivered alongside an error
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res_data.byte_valid && res_data.decode_error))
    else $error("byte delivered with error set");

    // Without a byte the data is zero
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.byte_valid |-> res_data.data_byte == 8'h00)
    else $error("data_byte not zero without byte_valid");

    // Error stays set until the token ends
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && err_open_reg |-> res_data.decode_error)
    else $error("sticky error dropped inside a token");

    // Taking a final character is followed by result activity
    assert property (@(posedge clk) disable iff (!rst_n)
        in_final |=> ##1 (res_valid || $past(res_valid && res_ready)))
    else $error("no result activity after final character");

endmodule

bind base64url_decoder_unit b64u_checker u_b64u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_data  (char_data),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_data   (res_data)
);

### tb/tb_base64url_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base64url_decoder_unit: self-checking bench for the base64url decoder
// Drives base64url tokens one character per transaction and predicts the
// decoded bytes, token_done and the sticky error flag for each character.
// Directed tokens cover the alphabet edges, padding, interior pads and
// invalid symbols. Random tokens, mostly well formed, run under several
// idle/stall mixes, including a long receiver hold-off that backs up the
// input channel.
// ----------------------------------------------------------------------------
module tb_base64url_decoder_unit;

    localparam int unsigned WATCHDOG_LIMIT  = 2000;
    localparam int unsigned HOLD_OFF_CYCLES = 80;
    localparam int unsigned DRAIN_CYCLES    = 8;
    localparam int unsigned PHASE_CHARS     = 150;

    // Predicts one result per character and checks the block against it
    class decode_checker;
        logic [11:0]            acc;
        logic [2:0]             held;
        logic                   pad_seen;
        logic                   err_seen;
        b64u_pkg::result_item_t expected_q[$];
        int unsigned            failures;
        int unsigned            chars_seen;
        int unsigned            tokens_seen;
        int unsigned            bytes_seen;
        int unsigned            bad_tokens;

        function new();
            acc         = '0;
            held        = '0;
            pad_seen    = 1'b0;
            err_seen    = 1'b0;
            failures    = 0;
            chars_seen  = 0;
            tokens_seen = 0;
            bytes_seen  = 0;
            bad_tokens  = 0;
        endfunction

        // Decode one accepted character and queue its expected result
        function void note_char(b64u_pkg::char_item_t c);
            b64u_pkg::result_item_t r;
            logic [7:0]             ch;
            logic [5:0]             sym;
            logic                   sym_ok;
            logic [3:0]             bits;
            ch     = c.text_char;
            r      = '0;
            sym    = '0;
            sym_ok = 1'b1;
            if (ch >= b64u_pkg::CHAR_UPPER_A && ch <= b64u_pkg::CHAR_UPPER_A + 8'd25)
                sym = 6'(ch - b64u_pkg::CHAR_UPPER_A);
            else if (ch >= b64u_pkg::CHAR_LOWER_A && ch <= b64u_pkg::CHAR_LOWER_A + 8'd25)
                sym = 6'(ch - b64u_pkg::CHAR_LOWER_A) + b64u_pkg::LOWER_BASE;
            else if (ch >= b64u_pkg::CHAR_DIGIT_0 && ch <= b64u_pkg::CHAR_DIGIT_0 + 8'd9)
                sym = 6'(ch - b64u_pkg::CHAR_DIGIT_0) + b64u_pkg::DIGIT_BASE;
            else if (ch == b64u_pkg::CHAR_DASH)
                sym = b64u_pkg::DASH_VALUE;
            else if (ch == b64u_pkg::CHAR_USCORE)
                sym = b64u_pkg::USCORE_VALUE;
            else
                sym_ok = 1'b0;

            // pad only marks; anything after a pad or off-alphabet is an error
            if (ch == b64u_pkg::CHAR_PAD)
                pad_seen = 1'b1;
            else if (pad_seen || !sym_ok)
                err_seen = 1'b1;
            else if (!err_seen)
            begin
                bits = {1'b0, held} + 4'd6;
                acc  = {acc[5:0], sym};
                if (bits >= 4'd8)
                begin
                    bits         = bits - 4'd8;
                    r.data_byte  = 8'(acc >> bits);
                    r.byte_valid = 1'b1;
                end
                held = bits[2:0];
            end

            r.token_done   = c.is_final;
            r.decode_error = err_seen;
            expected_q.insert(expected_q.size(), r);

            chars_seen++;
            if (r.byte_valid)
                bytes_seen++;
            if (c.is_final)
            begin
                tokens_seen++;
                if (err_seen)
                    bad_tokens++;
                acc      = '0;
                held     = '0;
                pad_seen = 1'b0;
                err_seen = 1'b0;
            end
        endfunction

        // Compare a result transaction with the oldest prediction
        function void check_result(b64u_pkg::result_item_t got);
            b64u_pkg::result_item_t exp_r;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result transaction: data_byte %0h byte_valid %0b",
                       got.data_byte, got.byte_valid);
                failures++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.data_byte !== exp_r.data_byte)
            begin
                $error("data_byte: expected %02h, actual %02h",
                       exp_r.data_byte, got.data_byte);
                failures++;
            end
            if (got.byte_valid !== exp_r.byte_valid)
            begin
                $error("byte_valid: expected %0b, actual %0b",
                       exp_r.byte_valid, got.byte_valid);
                failures++;
            end
            if (got.token_done !== exp_r.token_done)
            begin
                $error("token_done: expected %0b, actual %0b",
                       exp_r.token_done, got.token_done);
                failures++;
            end
            if (got.decode_error !== exp_r.decode_error)
            begin
                $error("decode_error: expected %0b, actual %0b",
                       exp_r.decode_error, got.decode_error);
                failures++;
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   char_valid;
    logic                   char_ready;
    b64u_pkg::char_item_t   char_data;
    logic                   res_valid;
    logic                   res_ready;
    b64u_pkg::result_item_t res_data;

    int unsigned   send_idle_pct;
    int unsigned   recv_stall_pct;
    logic          hold_off_req;
    logic          hold_off_done = 1'b0;
    int unsigned   chars_sent;
    int unsigned   quiet_cycles = 0;
    decode_checker dec_chk;

    base64url_decoder_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_data  (char_data),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_data   (res_data)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Offer one character, idling at random first, and wait for acceptance
    task automatic send_char(input b64u_pkg::char_item_t c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            char_valid <= 1'b0;
            @(posedge clk);
        end
        char_valid <= 1'b1;
        char_data  <= c;
        do
            @(posedge clk);
        while (!char_ready);
        chars_sent++;
    endtask

    // Whole token from a string, final flag on the last character
    task automatic send_text(input string s);
        b64u_pkg::char_item_t c;
        int                   i;
        for (i = 0; i < s.len(); i++)
        begin
            c.text_char = s[i];
            c.is_final  = (i == s.len() - 1);
            send_char(c);
        end
    endtask

    // Random token: mostly well formed, some with noise or interior pads
    task automatic send_random_token();
        b64u_pkg::char_item_t c;
        int unsigned          kind;
        int unsigned          len;
        int unsigned          pads;
        int unsigned          i;
        int unsigned          v;
        kind = $urandom_range(99);
        len  = ($urandom_range(19) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        pads = (kind < 80) ? $urandom_range(0, 2) : 0;
        for (i = 0; i < len + pads; i++)
        begin
            v = $urandom_range(63);
            if (i >= len)
                c.text_char = b64u_pkg::CHAR_PAD;
            else if (kind >= 80 && $urandom_range(4) == 0)
                c.text_char = 8'($urandom_range(255));
            else if (kind >= 90 && $urandom_range(5) == 0)
                c.text_char = b64u_pkg::CHAR_PAD;
            else if (v < b64u_pkg::LOWER_BASE)
                c.text_char = 8'(b64u_pkg::CHAR_UPPER_A + v);
            else if (v < b64u_pkg::DIGIT_BASE)
                c.text_char = 8'(b64u_pkg::CHAR_LOWER_A + (v - b64u_pkg::LOWER_BASE));
            else if (v < b64u_pkg::DASH_VALUE)
                c.text_char = 8'(b64u_pkg::CHAR_DIGIT_0 + (v - b64u_pkg::DIGIT_BASE));
            else if (v == b64u_pkg::DASH_VALUE)
                c.text_char = b64u_pkg::CHAR_DASH;
            else
                c.text_char = b64u_pkg::CHAR_USCORE;
            c.is_final = (i == len + pads - 1);
            send_char(c);
        end
    endtask

    // One idling mix, run for a number of characters
    task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct);
        int unsigned start;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start = chars_sent;
        while (chars_sent - start < PHASE_CHARS)
            send_random_token();
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin
        res_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_off_req && !hold_off_done)
            begin
                hold_off_done = 1'b1;
                res_ready    <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            res_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: note accepted characters, check results, watch for a hang
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (char_valid && char_ready)
                dec_chk.note_char(char_data);
            if (res_valid && res_ready)
                dec_chk.check_result(res_data);
            if ((char_valid && char_ready) || (res_valid && res_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Stimulus
    initial
    begin
        dec_chk        = new();
        chars_sent     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_req   = 1'b0;
        rst_n          = 1'b0;
        char_valid     <= 1'b0;
        char_data      <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // alphabet edges with leftover bits dropped at the final character
        send_text("Az09-_");
        // plain three-byte token
        send_text("QUJD");
        // pad run at the end
        send_text("QQ==");
        // symbol after a pad
        send_text("QQ=A");
        // invalid symbols, then data while the error is held
        send_char('{8'h00, 1'b0});
        send_char('{8'h2B, 1'b0});
        send_text("AB\377");
        // single-character token straight after an error token
        send_text("Z");

        // receiver holds off while characters keep coming
        hold_off_req <= 1'b1;
        run_phase(0, 0);
        run_phase(50, 0);
        run_phase(0, 50);
        run_phase(16, 16);
        char_valid <= 1'b0;

        // drain outstanding results, then allow for stray ones
        while (dec_chk.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d characters in %0d tokens: %0d bytes decoded,",
                 dec_chk.chars_seen, dec_chk.tokens_seen, dec_chk.bytes_seen);
        $display("%0d tokens ended flagged, %0d field mismatches",
                 dec_chk.bad_tokens, dec_chk.failures);
        if (dec_chk.failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
